@@ rtl/rhfu_pkg.sv @@
// Shared types, constants and helpers for the RTP H.264 FU-A packetizer.
package rhfu_pkg;

  localparam int LEN_PORT_BITS = 24;

  localparam logic [7:0]  RTP_VER_BYTE  = 8'h80;
  localparam logic [4:0]  FU_A_TYPE     = 5'd28;
  localparam logic [4:0]  NAL_SLICE     = 5'd1;
  localparam logic [4:0]  NAL_IDR       = 5'd5;
  localparam logic [10:0] PAYLOAD_MIN   = 11'd3;
  localparam logic [10:0] PAYLOAD_MAX   = 11'd1488;
  localparam logic [10:0] FU_OVERHEAD   = 11'd2;
  localparam logic [10:0] RTP_HDR_LEN   = 11'd12;
  localparam logic [10:0] FU_PKT_HDR    = 11'd14;

  localparam logic [1:0]  REG_SOURCE_ID    = 2'd0;
  localparam logic [1:0]  REG_PAYLOAD_TYPE = 2'd1;
  localparam logic [1:0]  REG_PAY_LIMIT    = 2'd2;
  localparam logic [1:0]  REG_TS_STEP      = 2'd3;

  localparam logic [31:0] RST_SOURCE_ID    = 32'h1234_5678;
  localparam logic [6:0]  RST_PAYLOAD_TYPE = 7'd96;
  localparam logic [10:0] RST_PAY_LIMIT    = 11'd1388;
  localparam logic [31:0] RST_TS_STEP      = 32'd3000;

  localparam logic [3:0]  IDX_FU_IND = 4'd12;
  localparam logic [3:0]  IDX_FU_HDR = 4'd13;

  typedef enum logic [1:0] {
    JOB_PAYLOAD,
    JOB_SINGLE,
    JOB_FRAG
  } job_kind_t;

  typedef struct packed {
    logic [31:0] source_id;
    logic [6:0]  payload_type;
    logic [10:0] pay_limit;
    logic [31:0] timestamp_step;
  } cfg_t;

  // Everything the serializer needs, besides the configuration, to emit the bytes of one input transaction.
  typedef struct packed {
    job_kind_t   kind;
    logic        marker;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [7:0]  fu_ind;
    logic [7:0]  fu_hdr;
    logic [7:0]  data;
    logic        pkt_end;
    logic [10:0] pkt_len;
  } job_t;

  function automatic logic [3:0] job_last_idx(job_kind_t k);
    logic [3:0] r;
    case (k)
      JOB_SINGLE: r = 4'd12;
      JOB_FRAG:   r = 4'd14;
      default:    r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic is_slice_or_idr(logic [7:0] hdr);
    return (hdr[4:0] == NAL_SLICE) || (hdr[4:0] == NAL_IDR);
  endfunction

endpackage

@@ rtl/rhfu_cfg.sv @@
// APB-style configuration register file of the packetizer.
module rhfu_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output rhfu_pkg::cfg_t      cfg
);
  import rhfu_pkg::*;

  logic [31:0] source_id_r;
  logic [6:0]  payload_type_r;
  logic [10:0] pay_limit_r;
  logic [31:0] ts_step_r;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_id_r    <= RST_SOURCE_ID;
      payload_type_r <= RST_PAYLOAD_TYPE;
      pay_limit_r    <= RST_PAY_LIMIT;
      ts_step_r      <= RST_TS_STEP;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SOURCE_ID:    source_id_r    <= pwdata;
        REG_PAYLOAD_TYPE: payload_type_r <= pwdata[6:0];
        REG_PAY_LIMIT:    pay_limit_r    <= pwdata[10:0];
        REG_TS_STEP:      ts_step_r      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SOURCE_ID:    prdata = source_id_r;
      REG_PAYLOAD_TYPE: prdata = {25'd0, payload_type_r};
      REG_PAY_LIMIT:    prdata = {21'd0, pay_limit_r};
      REG_TS_STEP:      prdata = ts_step_r;
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg.source_id      = source_id_r;
  assign cfg.payload_type   = payload_type_r;
  assign cfg.pay_limit      = pay_limit_r;
  assign cfg.timestamp_step = ts_step_r;

endmodule

@@ rtl/rhfu_ctrl.sv @@
// Stream state and per-transaction decision: single packet, fragment start or payload.
module rhfu_ctrl #(
  parameter int LENGTH_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rhfu_pkg::cfg_t      cfg,
  input  logic                in_fire,
  input  logic [7:0]          in_nalu_byte,
  input  logic                in_first_of_nalu,
  input  logic [23:0]         in_nalu_length,
  input  logic                in_restart_stream,
  output logic                job_go,
  output rhfu_pkg::job_t      job
);
  import rhfu_pkg::*;

  localparam int LW = (LENGTH_BITS < LEN_PORT_BITS) ? LENGTH_BITS : LEN_PORT_BITS;

  logic [15:0]   seq_r, seq_nxt, seq_base;
  logic [31:0]   ts_r, ts_nxt, ts_base;
  logic [7:0]    hdr_r, hdr_nxt;
  logic [LW-1:0] bytes_r, bytes_nxt;
  logic [10:0]   chunk_r, chunk_nxt;
  logic          frag_r, frag_nxt;
  logic          ff_r, ff_nxt;
  logic [10:0]   cur_len_r, cur_len_nxt;

  logic [10:0]   mp, fsz, chunk, chunk_cur;
  logic [LW-1:0] len;
  logic          start_frag, last;
  logic          go;

  assign len = in_nalu_length[LW-1:0];

  always_comb begin
    if (cfg.pay_limit < PAYLOAD_MIN)      mp = PAYLOAD_MIN;
    else if (cfg.pay_limit > PAYLOAD_MAX) mp = PAYLOAD_MAX;
    else                                  mp = cfg.pay_limit;
    fsz = mp - FU_OVERHEAD;
  end

  always_comb begin
    seq_nxt     = seq_r;
    ts_nxt      = ts_r;
    hdr_nxt     = hdr_r;
    bytes_nxt   = bytes_r;
    chunk_nxt   = chunk_r;
    frag_nxt    = frag_r;
    ff_nxt      = ff_r;
    cur_len_nxt = cur_len_r;
    go          = 1'b0;
    seq_base    = in_restart_stream ? 16'd0 : seq_r;
    ts_base     = in_restart_stream ? 32'd0 : ts_r;
    start_frag  = frag_r && (chunk_r == 11'd0);
    last        = bytes_r <= LW'(fsz);
    chunk       = last ? bytes_r[10:0] : fsz;
    chunk_cur   = start_frag ? chunk : chunk_r;

    job.kind    = JOB_PAYLOAD;
    job.marker  = last;
    job.seq     = seq_r;
    job.ts      = ts_r;
    job.fu_ind  = {hdr_r[7:5], FU_A_TYPE};
    job.fu_hdr  = {ff_r, last, 1'b0, hdr_r[4:0]};
    job.data    = in_nalu_byte;
    job.pkt_end = (chunk_cur - 11'd1) == 11'd0;
    job.pkt_len = start_frag ? FU_PKT_HDR + chunk : cur_len_r;

    if (in_first_of_nalu) begin
      seq_nxt   = seq_base;
      ts_nxt    = ts_base;
      bytes_nxt = '0;
      chunk_nxt = 11'd0;
      frag_nxt  = 1'b0;
      ff_nxt    = 1'b0;
      if (len != '0) begin
        hdr_nxt = in_nalu_byte;
        if (len <= LW'(mp)) begin
          // whole unit fits: one packet, header goes out with the NAL header byte
          go          = 1'b1;
          job.kind    = JOB_SINGLE;
          job.marker  = 1'b1;
          job.seq     = seq_base;
          job.ts      = ts_base;
          job.pkt_len = RTP_HDR_LEN + len[10:0];
          job.pkt_end = (len == LW'(1));
          cur_len_nxt = RTP_HDR_LEN + len[10:0];
          seq_nxt     = seq_base + 16'd1;
          chunk_nxt   = len[10:0] - 11'd1;
          bytes_nxt   = len - LW'(1);
          if ((len == LW'(1)) && is_slice_or_idr(in_nalu_byte))
            ts_nxt = ts_base + cfg.timestamp_step;
        end else begin
          frag_nxt  = 1'b1;
          ff_nxt    = 1'b1;
          bytes_nxt = len - LW'(1);
        end
      end
    end else if (bytes_r != '0) begin
      go        = 1'b1;
      chunk_nxt = chunk_cur - 11'd1;
      bytes_nxt = bytes_r - LW'(1);
      if (start_frag) begin
        job.kind    = JOB_FRAG;
        seq_nxt     = seq_r + 16'd1;
        ff_nxt      = 1'b0;
        cur_len_nxt = FU_PKT_HDR + chunk;
      end
      if (bytes_nxt == '0) begin
        if (is_slice_or_idr(hdr_r)) ts_nxt = ts_r + cfg.timestamp_step;
        frag_nxt = 1'b0;
        ff_nxt   = 1'b0;
      end
    end
  end

  assign job_go = in_fire && go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r     <= '0;
      ts_r      <= '0;
      hdr_r     <= '0;
      bytes_r   <= '0;
      chunk_r   <= '0;
      frag_r    <= 1'b0;
      ff_r      <= 1'b0;
      cur_len_r <= '0;
    end else if (in_fire) begin
      seq_r     <= seq_nxt;
      ts_r      <= ts_nxt;
      hdr_r     <= hdr_nxt;
      bytes_r   <= bytes_nxt;
      chunk_r   <= chunk_nxt;
      frag_r    <= frag_nxt;
      ff_r      <= ff_nxt;
      cur_len_r <= cur_len_nxt;
    end
  end

endmodule

@@ rtl/rhfu_emit.sv @@
// Job register and byte serializer feeding the registered output channel.
module rhfu_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  rhfu_pkg::cfg_t      cfg,
  input  logic                job_go,
  input  rhfu_pkg::job_t      job,
  output logic                job_free,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_packet_byte,
  output logic                out_packet_start,
  output logic                out_packet_end,
  output logic [10:0]         out_packet_length,
  output logic                out_run_end
);
  import rhfu_pkg::*;

  job_t        job_r;
  logic        job_valid_r;
  logic [3:0]  idx_r;
  logic        out_valid_r;
  logic [7:0]  byte_r;
  logic        start_r, end_r, run_end_r;
  logic [10:0] len_r;

  logic        out_load, last;
  logic [7:0]  cur_byte;

  assign last     = idx_r == job_last_idx(job_r.kind);
  assign out_load = job_valid_r && (!out_valid_r || out_ready);
  assign job_free = !job_valid_r || (out_load && last);

  always_comb begin
    if (last) begin
      cur_byte = job_r.data;
    end else begin
      case (idx_r)
        4'd0:       cur_byte = RTP_VER_BYTE;
        4'd1:       cur_byte = {job_r.marker, cfg.payload_type};
        4'd2:       cur_byte = job_r.seq[15:8];
        4'd3:       cur_byte = job_r.seq[7:0];
        4'd4:       cur_byte = job_r.ts[31:24];
        4'd5:       cur_byte = job_r.ts[23:16];
        4'd6:       cur_byte = job_r.ts[15:8];
        4'd7:       cur_byte = job_r.ts[7:0];
        4'd8:       cur_byte = cfg.source_id[31:24];
        4'd9:       cur_byte = cfg.source_id[23:16];
        4'd10:      cur_byte = cfg.source_id[15:8];
        4'd11:      cur_byte = cfg.source_id[7:0];
        IDX_FU_IND: cur_byte = job_r.fu_ind;
        IDX_FU_HDR: cur_byte = job_r.fu_hdr;
        default:    cur_byte = job_r.data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (out_load) idx_r <= last ? 4'd0 : idx_r + 4'd1;
      if (job_go)                job_valid_r <= 1'b1;
      else if (out_load && last) job_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_go) job_r <= job;
    if (out_load) begin
      byte_r    <= cur_byte;
      start_r   <= (idx_r == 4'd0) && (job_r.kind != JOB_PAYLOAD);
      end_r     <= last && job_r.pkt_end;
      run_end_r <= last;
      len_r     <= job_r.pkt_len;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_packet_byte   = byte_r;
  assign out_packet_start  = start_r;
  assign out_packet_end    = end_r;
  assign out_packet_length = len_r;
  assign out_run_end       = run_end_r;

endmodule

@@ rtl/rtp_h264_fu_a_packetizer.sv @@
// Top level of the RTP H.264 packetizer with FU-A fragmentation.
// Each accepted NAL byte yields 0, 1, 13 or 15 packet bytes: a unit that fits in one
// packet leaves its 12 RTP header bytes together with the NAL header byte, and each
// FU-A fragment leaves its 14 header bytes with its first payload byte. The output
// serializer emits one packet byte per cycle unless out_ready stalls it. The next
// input transaction is taken in the cycle the last result of the current one moves
// to the output register, so plain payload bytes stream at one per cycle while
// out_ready is high. The user must write registers over the APB-style port only
// while the block is idle; the block itself does not enforce it.
module rtp_h264_fu_a_packetizer #(
  parameter int LENGTH_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_nalu_byte,
  input  logic        in_first_of_nalu,
  input  logic [23:0] in_nalu_length,
  input  logic        in_restart_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_packet_byte,
  output logic        out_packet_start,
  output logic        out_packet_end,
  output logic [10:0] out_packet_length,
  output logic        out_run_end
);
  import rhfu_pkg::*;

  cfg_t cfg;
  job_t job;
  logic job_go;
  logic job_free;
  logic in_fire;

  assign in_ready = job_free;
  assign in_fire  = in_valid && in_ready;

  rhfu_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rhfu_ctrl #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_fire           (in_fire),
    .in_nalu_byte      (in_nalu_byte),
    .in_first_of_nalu  (in_first_of_nalu),
    .in_nalu_length    (in_nalu_length),
    .in_restart_stream (in_restart_stream),
    .job_go            (job_go),
    .job               (job)
  );

  rhfu_emit u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .job_go            (job_go),
    .job               (job),
    .job_free          (job_free),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_packet_byte   (out_packet_byte),
    .out_packet_start  (out_packet_start),
    .out_packet_end    (out_packet_end),
    .out_packet_length (out_packet_length),
    .out_run_end       (out_run_end)
  );

`ifndef SYNTHESIS
  // a header byte never closes a transaction's run
  a_start_not_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_packet_start) |-> !out_run_end)
    else $error("packet start flagged as run end");

  // packets always end on a payload byte, the last result of its transaction
  a_end_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_packet_end) |-> out_run_end)
    else $error("packet end without run end");

  a_length_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_packet_length >= 11'd13 && out_packet_length <= 11'd1500))
    else $error("packet length out of range");
`endif

endmodule
